### rtl/p3d_pkg.sv
// Shared types and constants for the POP3 response deframer.
`default_nettype none

package p3d_pkg;

  // Characters of interest in the raw stream
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChUpO   = 8'h4F;
  localparam logic [7:0] ChLoO   = 8'h6F;
  localparam logic [7:0] ChUpK   = 8'h4B;
  localparam logic [7:0] ChLoK   = 8'h6B;

  // Terminator lengths in delivered bytes
  localparam logic [2:0] StripNone    = 3'd0;
  localparam logic [2:0] StripLf      = 3'd1;
  localparam logic [2:0] StripCrLf    = 3'd2;
  localparam logic [2:0] StripLfDotLf = 3'd3;
  localparam logic [2:0] StripFull    = 3'd5;

  // Byte count saturation
  localparam logic [2:0] SeenMax = 3'd4;

  // Position within a line, for dot-unstuffing
  typedef enum logic [1:0] {
    PH_MID   = 2'd0,
    PH_START = 2'd1,
    PH_DOT   = 2'd2
  } line_phase_e;

  // First-line class
  typedef enum logic [1:0] {
    CLS_READY = 2'd0,
    CLS_OK    = 2'd1,
    CLS_ERR   = 2'd2,
    CLS_PEND  = 2'd3
  } status_class_e;

  // Per-response tracking state
  typedef struct packed {
    logic [31:0]   recent;  // last four raw bytes, newest in low byte
    line_phase_e   phase;
    logic [2:0]    seen;    // saturates at four
    status_class_e cls;
    logic          minus;   // first byte was '-'
  } p3d_state_t;

  localparam p3d_state_t StateRst = '{
    recent: 32'd0,
    phase:  PH_MID,
    seen:   3'd0,
    cls:    CLS_ERR,
    minus:  1'b0
  };

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] strip;
    logic       done;
    logic       valid;
    logic [7:0] data;
  } p3d_result_t;

endpackage

`default_nettype wire

### rtl/p3d_step.sv
// Per-byte terminator detection, first-line classification and dot-unstuffing.
`default_nettype none

module p3d_step
  import p3d_pkg::*;
(
  input  var p3d_state_t  state_i,
  input  var logic        multi_i,
  input  var logic [7:0]  byte_i,
  output p3d_state_t      state_o,
  output p3d_result_t     result_o
);

  logic [7:0]    p0, p1, p2, p3;
  logic [2:0]    count;
  status_class_e cls;
  logic          minus;
  logic          done;
  logic [2:0]    strip;
  logic          valid;
  line_phase_e   phase;
  logic          is_lf;

  assign p0    = state_i.recent[7:0];
  assign p1    = state_i.recent[15:8];
  assign p2    = state_i.recent[23:16];
  assign p3    = state_i.recent[31:24];
  assign count = state_i.seen + 3'd1;
  assign is_lf = (byte_i == ChLf);

  // First-line classification over the first three bytes
  always_comb begin
    cls   = state_i.cls;
    minus = state_i.minus;
    case (state_i.seen)
      3'd0: begin
        cls   = (byte_i == ChPlus) ? CLS_PEND : CLS_ERR;
        minus = (byte_i == ChMinus);
      end
      3'd1: begin
        if (state_i.cls == CLS_PEND) begin
          if (byte_i == ChSpace || byte_i == ChTab) begin
            cls = CLS_READY;
          end else if (byte_i != ChUpO && byte_i != ChLoO) begin
            cls = CLS_ERR;
          end
        end
      end
      3'd2: begin
        if (state_i.cls == CLS_PEND) begin
          cls = (byte_i == ChUpK || byte_i == ChLoK) ? CLS_OK : CLS_ERR;
        end
      end
      default: ;
    endcase
  end

  // End of response, found on raw bytes
  always_comb begin
    done  = 1'b0;
    strip = StripNone;
    if (is_lf) begin
      if (multi_i) begin
        if (count >= 3'd5 && p0 == ChCr && p1 == ChDot && p2 == ChLf && p3 == ChCr) begin
          done  = 1'b1;
          strip = StripFull;
        end else if (count >= 3'd3 && p0 == ChDot && p1 == ChLf) begin
          done  = 1'b1;
          strip = StripLfDotLf;
        end else if (minus && count >= 3'd4) begin
          done  = 1'b1;
          strip = (p0 == ChCr) ? StripCrLf : StripLf;
        end
      end else begin
        done  = 1'b1;
        strip = (count >= 3'd2 && p0 == ChCr) ? StripCrLf : StripLf;
      end
    end
  end

  // Dot-unstuffing: drop the second dot at line start
  always_comb begin
    valid = 1'b1;
    phase = PH_MID;
    if (is_lf) begin
      phase = PH_START;
    end else if (state_i.phase == PH_START && byte_i == ChDot) begin
      phase = PH_DOT;
    end else if (state_i.phase == PH_DOT && byte_i == ChDot) begin
      valid = 1'b0;
    end
  end

  // Result and next state; rearm on done
  always_comb begin
    result_o.data   = byte_i;
    result_o.valid  = valid;
    result_o.done   = done;
    result_o.strip  = strip;
    result_o.status = done ? ((cls == CLS_PEND) ? CLS_ERR : cls) : CLS_READY;

    if (done) begin
      state_o = StateRst;
    end else begin
      state_o.recent = {state_i.recent[23:0], byte_i};
      state_o.phase  = phase;
      state_o.seen   = (count > SeenMax) ? SeenMax : count;
      state_o.cls    = cls;
      state_o.minus  = minus;
    end
  end

endmodule

`default_nettype wire

### rtl/pop3_response_deframer_core.sv
// Top level of the POP3 response deframer with dot-unstuffing.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid_i/tready_o      tdata[7:0] data_byte
//   m_axis    out  m_axis_tvalid_o/tready_i      tdata out_byte, strip_count, status;
//                                                tuser out_valid; tlast done_res
//   cfg       in   cfg_we_i                      cfg_wdata_i multi_line_mode
//
// One item per cycle unless a held result stalls; the tracking state and the
// result register are loaded at the edge where an input item is accepted.
// Reset clears the tracking state, the mode register and the output valid.
// The input is ready whenever the result register is empty or being drained,
// so the input waits only in cycles where a held result is stalled.
`default_nettype none

module pop3_response_deframer_core
  import p3d_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // configuration
  input  var logic        cfg_we_i,
  input  var logic        cfg_wdata_i,       // [0] multi_line_mode
  // input stream
  input  var logic        s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  var logic [7:0]  s_axis_tdata_i,    // [7:0] data_byte
  // result stream
  output logic            m_axis_tvalid_o,
  input  var logic        m_axis_tready_i,
  output logic [15:0]     m_axis_tdata_o,    // [7:0] out_byte, [10:8] strip_count,
                                             // [12:11] status, [15:13] zero
  output logic            m_axis_tuser_o,    // [0] out_valid
  output logic            m_axis_tlast_o     // done_res
);

  logic        multi_q;
  p3d_state_t  state_q, state_d;
  p3d_result_t res_q, res_d;
  logic        out_vld_q;
  logic        in_acc;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Per-byte logic
  p3d_step u_step (
    .state_i  (state_q),
    .multi_i  (multi_q),
    .byte_i   (s_axis_tdata_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multi_q <= 1'b0;
    end else if (cfg_we_i) begin
      multi_q <= cfg_wdata_i;
    end
  end

  // Tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_vld_q <= s_axis_tvalid_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, res_q.status, res_q.strip, res_q.data};
  assign m_axis_tuser_o  = res_q.valid;
  assign m_axis_tlast_o  = res_q.done;

endmodule

`default_nettype wire
